// ===== rtl/core/sdti_pkg.sv =====
// Package for the standard drag table interpolator: breakpoint tables,
// widths, model codes and the rounding functions that build the ROM contents.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdti_pkg;

  localparam int MACH_W = 16;
  localparam int OUT_W  = 16;
  localparam int FRAC_W = 16;
  localparam int Q_W    = FRAC_W + 1;
  localparam int IDX_W  = 7;
  localparam int ROM_AW = IDX_W + 1;
  localparam int ROM_D  = 2 ** ROM_AW;

  localparam int DEF_MACH_FRAC_BITS = 12;
  localparam int DEF_CD_FRAC_BITS   = 16;

  typedef enum logic {
    MODEL_G1 = 1'b0,
    MODEL_G7 = 1'b1
  } model_t;

  localparam int G1_N = 79;
  localparam int G7_N = 84;

  localparam logic [IDX_W-1:0] LAST_G1 = IDX_W'(G1_N - 1);
  localparam logic [IDX_W-1:0] LAST_G7 = IDX_W'(G7_N - 1);

  localparam int unsigned G1_MILLI [G1_N] = '{
    0, 50, 100, 150, 200, 250, 300, 350, 400, 450, 500, 550, 600,
    700, 725, 750, 775, 800, 825, 850, 875, 900, 925, 950, 975, 1000,
    1025, 1050, 1075, 1100, 1125, 1150, 1200, 1250, 1300, 1350, 1400, 1450,
    1500, 1550, 1600, 1650, 1700, 1750, 1800, 1850, 1900, 1950, 2000, 2050,
    2100, 2150, 2200, 2250, 2300, 2350, 2400, 2450, 2500, 2600, 2700, 2800,
    2900, 3000, 3100, 3200, 3300, 3400, 3500, 3600, 3700, 3800, 3900, 4000,
    4200, 4400, 4600, 4800, 5000
  };

  localparam int unsigned G1_CD [G1_N] = '{
    2629, 2558, 2487, 2413, 2344, 2278, 2214, 2155, 2104, 2061, 2032, 2020, 2034,
    2165, 2230, 2313, 2417, 2546, 2706, 2901, 3136, 3415, 3734, 4084, 4448, 4805,
    5136, 5427, 5677, 5883, 6053, 6191, 6393, 6518, 6589, 6621, 6625, 6607,
    6573, 6528, 6474, 6413, 6347, 6280, 6210, 6141, 6072, 6003, 5934, 5867,
    5804, 5743, 5685, 5630, 5577, 5527, 5481, 5438, 5397, 5325, 5264, 5211,
    5168, 5133, 5105, 5084, 5067, 5054, 5040, 5030, 5022, 5016, 5010, 5006,
    4998, 4995, 4992, 4990, 4988
  };

  localparam int unsigned G7_MILLI [G7_N] = '{
    0, 50, 100, 150, 200, 250, 300, 350, 400, 450, 500, 550, 600, 650, 700,
    725, 750, 775, 800, 825, 850, 875, 900, 925, 950, 975, 1000, 1025, 1050,
    1075, 1100, 1125, 1150, 1200, 1250, 1300, 1350, 1400, 1500, 1550, 1600,
    1650, 1700, 1750, 1800, 1850, 1900, 1950, 2000, 2050, 2100, 2150, 2200,
    2250, 2300, 2350, 2400, 2450, 2500, 2550, 2600, 2650, 2700, 2750, 2800,
    2850, 2900, 2950, 3000, 3100, 3200, 3300, 3400, 3500, 3600, 3700, 3800,
    3900, 4000, 4200, 4400, 4600, 4800, 5000
  };

  localparam int unsigned G7_CD [G7_N] = '{
    1198, 1197, 1196, 1194, 1193, 1194, 1194, 1194, 1193, 1193, 1194, 1193, 1194,
    1197, 1202, 1207, 1215, 1226, 1242, 1266, 1306, 1368, 1464, 1660, 2054,
    2993, 3803, 4015, 4043, 4034, 4014, 3987, 3955, 3884, 3810, 3732, 3657,
    3580, 3440, 3376, 3315, 3260, 3209, 3160, 3117, 3078, 3042, 3010, 2980,
    2951, 2922, 2892, 2864, 2835, 2807, 2779, 2752, 2725, 2697, 2670, 2643,
    2615, 2588, 2561, 2533, 2506, 2479, 2451, 2424, 2368, 2313, 2258, 2205,
    2154, 2106, 2060, 2017, 1975, 1935, 1861, 1793, 1730, 1672, 1618
  };

  // Round milli-Mach to the nearest step of a Q format with fb fraction bits.
  function automatic longint unsigned rnd_mach(longint unsigned milli, int fb);
    return (milli * (longint'(1) << fb) + 500) / 1000;
  endfunction

  // Round Cd in units of 1e-4 to the nearest step of Q0.fb.
  function automatic longint unsigned rnd_cd(longint unsigned cd_e4, int fb);
    return (cd_e4 * (longint'(1) << fb) + 5000) / 10000;
  endfunction

  // Breakpoint Mach; entries past the table end read as all ones of mw bits.
  function automatic longint unsigned mach_entry(bit g7, int idx, int fb, int mw);
    longint unsigned pad;
    pad = (longint'(1) << mw) - 1;
    if (g7) begin
      if (idx >= G7_N) begin
        return pad;
      end
      return rnd_mach(longint'(G7_MILLI[idx]), fb);
    end
    if (idx >= G1_N) begin
      return pad;
    end
    return rnd_mach(longint'(G1_MILLI[idx]), fb);
  endfunction

  function automatic longint unsigned cd_entry(bit g7, int idx, int fb);
    if (g7) begin
      if (idx >= G7_N) begin
        return 0;
      end
      return rnd_cd(longint'(G7_CD[idx]), fb);
    end
    if (idx >= G1_N) begin
      return 0;
    end
    return rnd_cd(longint'(G1_CD[idx]), fb);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/standard_drag_table_interp.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mach (Q4.12)
// output    out        out_valid/out_stall  drag_coeff (Q0.16)
// config    in         cfg_we               cfg_wdata (drag model)
//
// One transaction per cycle while the skid register is empty; the pipeline depth is set
// by the seven-step breakpoint search and the one-bit-per-stage divider.
// Reset clears all valid bits, the output and skid valid flags, and selects G1.
// The pipeline advances as a whole while the skid register is empty; a stalled
// output parks one result in the skid register, then input stall rises.
// Depends on sdti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module standard_drag_table_interp
  import sdti_pkg::*;
#(
  parameter int MACH_FRAC_BITS = DEF_MACH_FRAC_BITS,
  parameter int CD_FRAC_BITS   = DEF_CD_FRAC_BITS
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire               cfg_wdata,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [MACH_W-1:0] mach,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [OUT_W-1:0]  drag_coeff
);

  localparam int MW    = (MACH_FRAC_BITS + 3 > MACH_W + 1) ? MACH_FRAC_BITS + 3 : MACH_W + 1;
  localparam int DW    = MACH_FRAC_BITS - 1;
  localparam int CW    = CD_FRAC_BITS;
  localparam int EW    = (CW > OUT_W) ? CW : OUT_W;
  localparam int NSRCH = IDX_W;
  localparam int NST   = NSRCH + Q_W + 4;

  typedef struct packed {
    logic [MACH_W-1:0] x;
    model_t            model;
    logic              lo_end;
    logic              hi_end;
    logic [IDX_W-1:0]  cnt;
  } srch_t;

  typedef struct packed {
    logic [MACH_W-1:0] x;
    logic              lo_end;
    logic              hi_end;
    logic [MW-1:0]     m_lo;
    logic [MW-1:0]     m_hi;
    logic [CW-1:0]     cd_lo;
    logic [CW-1:0]     cd_hi;
  } fetch_t;

  typedef struct packed {
    logic [DW-1:0]  rem;
    logic [DW-1:0]  den;
    logic [Q_W-1:0] q;
    logic [CW-1:0]  cd_lo;
    logic [CW-1:0]  dmag;
    logic           dneg;
  } div_t;

  typedef struct packed {
    logic [CW-1:0] cd_lo;
    logic          dneg;
    logic [CW-1:0] p;
  } mul_t;

  logic [MW-1:0] mach_rom [ROM_D];
  logic [CW-1:0] cd_rom   [ROM_D];

  for (genvar g = 0; g < ROM_D; g++) begin : g_rom
    assign mach_rom[g] = MW'(mach_entry(((g >> IDX_W) != 0), g & (2 ** IDX_W - 1),
                                        MACH_FRAC_BITS, MW));
    assign cd_rom[g]   = CW'(cd_entry(((g >> IDX_W) != 0), g & (2 ** IDX_W - 1),
                                      CD_FRAC_BITS));
  end

  model_t           drag_model;
  logic [NST-1:0]   vld;
  logic             adv;
  logic             skid_vld;
  logic [OUT_W-1:0] skid_data;
  logic             take;
  logic             fin;

  srch_t  srch [NSRCH+1];
  fetch_t fch;
  div_t   div  [Q_W+1];
  mul_t   mul;

  assign adv      = !skid_vld;
  assign in_stall = skid_vld;
  assign take     = out_valid && !out_stall;
  assign fin      = adv && vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_model <= MODEL_G1;
      vld        <= '0;
    end else begin
      if (cfg_we) begin
        drag_model <= model_t'(cfg_wdata);
      end
      if (adv) begin
        vld <= {vld[NST-2:0], in_valid};
      end
    end
  end

  // Input register with end-of-table checks
  logic [IDX_W-1:0] last_in;
  logic [MW-1:0]    x_in;

  always_comb begin
    last_in = (drag_model == MODEL_G7) ? LAST_G7 : LAST_G1;
    x_in    = MW'(mach);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      srch[0].x      <= mach;
      srch[0].model  <= drag_model;
      srch[0].lo_end <= x_in <= mach_rom[{drag_model, IDX_W'(0)}];
      srch[0].hi_end <= x_in >= mach_rom[{drag_model, last_in}];
      srch[0].cnt    <= '0;
    end
  end

  // Binary search: count breakpoints below x, one index bit per stage
  for (genvar s = 0; s < NSRCH; s++) begin : g_srch
    localparam logic [IDX_W-1:0] STEP = IDX_W'(1) << (NSRCH - 1 - s);
    logic [IDX_W-1:0] trial;
    logic [IDX_W-1:0] probe;
    logic [MW-1:0]    pm;
    srch_t            srch_next;

    always_comb begin
      trial     = srch[s].cnt | STEP;
      probe     = trial - IDX_W'(1);
      pm        = mach_rom[{srch[s].model, probe}];
      srch_next = srch[s];
      if (pm < MW'(srch[s].x)) begin
        srch_next.cnt = trial;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        srch[s+1] <= srch_next;
      end
    end
  end

  // Segment fetch
  logic [IDX_W-1:0] hi_idx;
  logic [IDX_W-1:0] lo_idx;

  always_comb begin
    if (srch[NSRCH].lo_end) begin
      hi_idx = IDX_W'(1);
    end else if (srch[NSRCH].hi_end) begin
      hi_idx = (srch[NSRCH].model == MODEL_G7) ? LAST_G7 : LAST_G1;
    end else begin
      hi_idx = srch[NSRCH].cnt;
    end
    lo_idx = hi_idx - IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fch.x      <= srch[NSRCH].x;
      fch.lo_end <= srch[NSRCH].lo_end;
      fch.hi_end <= srch[NSRCH].hi_end;
      fch.m_lo   <= mach_rom[{srch[NSRCH].model, lo_idx}];
      fch.m_hi   <= mach_rom[{srch[NSRCH].model, hi_idx}];
      fch.cd_lo  <= cd_rom[{srch[NSRCH].model, lo_idx}];
      fch.cd_hi  <= cd_rom[{srch[NSRCH].model, hi_idx}];
    end
  end

  // Divider operands; ends force a fraction of zero or one
  logic [DW-1:0] den;
  logic [DW-1:0] num;
  logic          dneg;
  logic [CW-1:0] dmag;

  always_comb begin
    den  = DW'(fch.m_hi - fch.m_lo);
    if (fch.lo_end) begin
      num = '0;
    end else if (fch.hi_end) begin
      num = den;
    end else begin
      num = DW'(MW'(fch.x) - fch.m_lo);
    end
    dneg = fch.cd_hi < fch.cd_lo;
    dmag = dneg ? fch.cd_lo - fch.cd_hi : fch.cd_hi - fch.cd_lo;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div[0].rem   <= num;
      div[0].den   <= den;
      div[0].q     <= '0;
      div[0].cd_lo <= fch.cd_lo;
      div[0].dmag  <= dmag;
      div[0].dneg  <= dneg;
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [DW:0]   t;
    logic          qb;
    logic [DW-1:0] nrem;
    div_t          div_next;

    always_comb begin
      if (j == 0) begin
        t = {1'b0, div[j].rem};
      end else begin
        t = {div[j].rem, 1'b0};
      end
      qb           = t >= {1'b0, div[j].den};
      nrem         = DW'(qb ? t - {1'b0, div[j].den} : t);
      div_next     = div[j];
      div_next.rem = nrem;
      div_next.q   = {div[j].q[Q_W-2:0], qb};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div[j+1] <= div_next;
      end
    end
  end

  // Scale the Cd step by the fraction
  logic [CW+Q_W-1:0] prod;

  assign prod = (CW+Q_W)'(div[Q_W].dmag) * (CW+Q_W)'(div[Q_W].q);

  always_ff @(posedge clk) begin
    if (adv) begin
      mul.cd_lo <= div[Q_W].cd_lo;
      mul.dneg  <= div[Q_W].dneg;
      mul.p     <= CW'(prod >> FRAC_W);
    end
  end

  // Final add and saturation
  logic [CW-1:0]    res;
  logic [EW-1:0]    res_ext;
  logic [OUT_W-1:0] res_sat;

  always_comb begin
    res     = mul.dneg ? mul.cd_lo - mul.p : mul.cd_lo + mul.p;
    res_ext = EW'(res);
    res_sat = (res_ext > EW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : res_ext[OUT_W-1:0];
  end

  // Output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (fin) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        drag_coeff <= skid_data;
      end
    end else if (fin) begin
      if (!out_valid || take) begin
        drag_coeff <= res_sat;
      end else begin
        skid_data <= res_sat;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  a_inner_segment: assert property (@(posedge clk) disable iff (rst)
    vld[NSRCH] && !srch[NSRCH].lo_end && !srch[NSRCH].hi_end |-> srch[NSRCH].cnt != '0)
    else $error("search picked segment zero for an inner Mach value");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSRCH + Q_W + 2] |-> div[Q_W].q <= (Q_W'(1) << FRAC_W))
    else $error("interpolation fraction above one");

  a_within_segment: assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] |-> (mul.dneg ? res <= mul.cd_lo : res >= mul.cd_lo))
    else $error("interpolated Cd left its segment");
`endif

endmodule

`default_nettype wire
